@@ hdl/assert_macros.svh @@
// Assertion macros shared by the framebuffer blitter RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every clock edge out of reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked on every clock edge out of reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ hdl/pmfb_pkg.sv @@
// Shared types and constants for the paged monochrome framebuffer blitter.
// Used by the controller, the datapath and the top level; depends on nothing.
package pmfb_pkg;

    // Screen geometry: pages of eight pixel rows, one byte per column.
    localparam int SCREEN_COLS  = 128;
    localparam int SCREEN_PAGES = 8;
    localparam int STORE_BYTES  = SCREEN_COLS * SCREEN_PAGES;
    localparam int ADDR_W       = $clog2(STORE_BYTES);
    localparam int COL_W        = $clog2(SCREEN_COLS);
    localparam int PAGE_W       = (SCREEN_PAGES > 1) ? $clog2(SCREEN_PAGES) : 1;

    // Request codes.
    typedef enum logic [2:0] {
        REQ_CLEAR      = 3'd0,
        REQ_PUT_PIXEL  = 3'd1,
        REQ_BLIT_START = 3'd2,
        REQ_BLIT_DATA  = 3'd3,
        REQ_READ_BYTE  = 3'd4
    } t_req;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // latch a new request
        logic clr_wr;    // write zero at the clear counter and advance it
        logic rd_top;    // read the target byte
        logic wr_top;    // write the modified target byte
        logic rd_bot;    // read the byte one page below
        logic wr_bot;    // write the modified lower byte
        logic cap_read;  // capture read data as the result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic top_ok;    // the target byte is to be accessed
        logic bot_ok;    // the lower byte is to be written too
        logic is_read;   // the latched request is a byte read
        logic clr_last;  // the clear counter is at the last address
    } t_stat;

endpackage

@@ hdl/pmfb_ctrl.sv @@
// Controller state machine of the framebuffer blitter.
// Sequences clear sweeps and read-modify-write accesses; uses pmfb_pkg.
module pmfb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [2:0]      i_req_type,
    input  pmfb_pkg::t_stat i_stat,
    output pmfb_pkg::t_cmd  o_cmd,
    output logic            o_busy,
    output logic            o_result_valid
);
    import pmfb_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CLR    = 7'b0000010,
        S_RD_TOP = 7'b0000100,
        S_WR_TOP = 7'b0001000,
        S_RD_BOT = 7'b0010000,
        S_WR_BOT = 7'b0100000,
        S_FIN    = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_init, n_init;

    // State and init flag. Reset starts a silent sweep that zeroes the store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_init  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
        end
    end

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        n_init  = r_init;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    case (t_req'(i_req_type))
                        REQ_CLEAR:     n_state = S_CLR;
                        REQ_PUT_PIXEL: n_state = S_RD_TOP;
                        REQ_BLIT_DATA: n_state = S_RD_TOP;
                        REQ_READ_BYTE: n_state = S_RD_TOP;
                        default:       n_state = S_FIN;
                    endcase
                end
            end
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = r_init ? S_IDLE : S_FIN;
                    n_init  = 1'b0;
                end
            end
            S_RD_TOP: begin
                if (i_stat.top_ok) begin
                    o_cmd.rd_top = 1'b1;
                    n_state      = S_WR_TOP;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_WR_TOP: begin
                if (i_stat.is_read) begin
                    o_cmd.cap_read = 1'b1;
                    n_state        = S_FIN;
                end else begin
                    o_cmd.wr_top = 1'b1;
                    n_state      = i_stat.bot_ok ? S_RD_BOT : S_FIN;
                end
            end
            S_RD_BOT: begin
                o_cmd.rd_bot = 1'b1;
                n_state      = S_WR_BOT;
            end
            S_WR_BOT: begin
                o_cmd.wr_bot = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_result_valid = (r_state == S_FIN);

endmodule

@@ hdl/pmfb_dpath.sv @@
// Datapath of the framebuffer blitter: frame store, blit state and result registers.
// Driven by pmfb_ctrl through t_cmd; uses pmfb_pkg.
module pmfb_dpath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pmfb_pkg::t_cmd  i_cmd,
    input  logic [2:0]      i_req_type,
    input  logic [7:0]      i_pos_x,
    input  logic [7:0]      i_pos_y,
    input  logic            i_pixel_on,
    input  logic [7:0]      i_sprite_width,
    input  logic [7:0]      i_sprite_height,
    input  logic [7:0]      i_sprite_byte,
    output pmfb_pkg::t_stat o_stat,
    output logic [7:0]      o_read_data,
    output logic            o_blit_done,
    output logic            o_req_error
);
    import pmfb_pkg::*;

    // Frame store with one write and one registered read port.
    logic [7:0] r_mem [STORE_BYTES];
    logic [7:0] r_rdata;

    // Blit state, cleared by reset.
    logic [7:0] r_col0, r_w, r_h, r_cur_col, r_cur_row;
    logic [4:0] r_page0;
    logic [2:0] r_bshift;
    logic       r_active;

    // Latched request.
    t_req       r_req;
    logic [8:0] r_col, r_page;
    logic [2:0] r_shift;
    logic [7:0] r_src;
    logic       r_pon;
    logic [7:0] r_rd;
    logic       r_done, r_err;

    logic [ADDR_W-1:0] r_clr_cnt;

    t_req              req_in;
    logic [7:0]        n_cur_col, n_cur_row;
    logic              n_active, n_done;
    logic [7:0]        inc_col, inc_row;
    logic              top_on, bot_on;
    logic [COL_W-1:0]  col_idx;
    logic [PAGE_W-1:0] page_idx;
    logic [ADDR_W-1:0] top_addr, bot_addr, waddr, raddr;
    logic [7:0]        low_mask, bit_mask, top_data, bot_data, wdata;
    logic              we, re;

    assign req_in = t_req'(i_req_type);

    // Cursor advance for one sprite byte, row-major.
    always_comb begin
        inc_col   = r_cur_col + 8'd1;
        inc_row   = r_cur_row + 8'd1;
        n_cur_col = inc_col;
        n_cur_row = r_cur_row;
        n_active  = r_active;
        n_done    = 1'b0;
        if (inc_col >= r_w) begin
            n_cur_col = 8'd0;
            n_cur_row = inc_row;
            if (inc_row >= r_h) begin
                n_cur_row = 8'd0;
                n_active  = 1'b0;
                n_done    = 1'b1;
            end
        end
    end

    // Blit state updates on blit_start and blit_data requests.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col0    <= '0;
            r_page0   <= '0;
            r_bshift  <= '0;
            r_w       <= '0;
            r_h       <= '0;
            r_cur_col <= '0;
            r_cur_row <= '0;
            r_active  <= 1'b0;
        end else if (i_cmd.accept) begin
            if (req_in == REQ_BLIT_START) begin
                r_col0    <= i_pos_x;
                r_page0   <= i_pos_y[7:3];
                r_bshift  <= i_pos_y[2:0];
                r_w       <= i_sprite_width;
                r_h       <= i_sprite_height;
                r_cur_col <= '0;
                r_cur_row <= '0;
                r_active  <= (i_sprite_width != 8'd0) && (i_sprite_height != 8'd0);
            end else if (req_in == REQ_BLIT_DATA && r_active) begin
                r_cur_col <= n_cur_col;
                r_cur_row <= n_cur_row;
                r_active  <= n_active;
            end
        end
    end

    // Latch the target location and flags of a new request.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= req_in;
            r_src <= i_sprite_byte;
            r_pon <= i_pixel_on;
            r_rd  <= 8'd0;
            case (req_in)
                REQ_PUT_PIXEL: begin
                    r_col   <= {1'b0, i_pos_x};
                    r_page  <= {4'd0, i_pos_y[7:3]};
                    r_shift <= i_pos_y[2:0];
                    r_err   <= 1'b0;
                    r_done  <= 1'b0;
                end
                REQ_BLIT_DATA: begin
                    r_col   <= {1'b0, r_col0} + {1'b0, r_cur_col};
                    r_page  <= {4'd0, r_page0} + {1'b0, r_cur_row};
                    r_shift <= r_bshift;
                    r_err   <= !r_active;
                    r_done  <= r_active && n_done;
                end
                default: begin
                    r_col   <= {1'b0, i_pos_x};
                    r_page  <= {1'b0, i_pos_y};
                    r_shift <= i_pos_y[2:0];
                    r_err   <= 1'b0;
                    r_done  <= 1'b0;
                end
            endcase
        end else if (i_cmd.cap_read) begin
            r_rd <= r_rdata;
        end
    end

    // Clear counter walks the whole store one byte a cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.accept) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_cnt <= r_clr_cnt + ADDR_W'(1);
        end
    end

    // Screen bounds and store addresses.
    always_comb begin
        top_on   = (r_col < 9'(SCREEN_COLS)) && (r_page < 9'(SCREEN_PAGES));
        bot_on   = (r_col < 9'(SCREEN_COLS))
                   && (({1'b0, r_page} + 10'd1) < 10'(SCREEN_PAGES));
        col_idx  = r_col[COL_W-1:0];
        page_idx = r_page[PAGE_W-1:0];
        top_addr = ADDR_W'(int'(page_idx) * SCREEN_COLS) + ADDR_W'(col_idx);
        bot_addr = top_addr + ADDR_W'(SCREEN_COLS);
    end

    // Status for the controller.
    always_comb begin
        o_stat          = '0;
        o_stat.is_read  = (r_req == REQ_READ_BYTE);
        o_stat.clr_last = (r_clr_cnt == ADDR_W'(STORE_BYTES - 1));
        case (r_req)
            REQ_PUT_PIXEL: o_stat.top_ok = top_on;
            REQ_READ_BYTE: o_stat.top_ok = top_on;
            REQ_BLIT_DATA: begin
                o_stat.top_ok = top_on && !r_err;
                o_stat.bot_ok = bot_on && !r_err && (r_shift != 3'd0);
            end
            default: begin
            end
        endcase
    end

    // Merge logic for the two pages and the single pixel.
    always_comb begin
        low_mask = 8'hFF >> (4'd8 - {1'b0, r_shift});
        bit_mask = 8'd1 << r_shift;
        if (r_req == REQ_PUT_PIXEL) begin
            top_data = r_pon ? (r_rdata | bit_mask) : (r_rdata & ~bit_mask);
        end else begin
            top_data = (r_rdata & low_mask) | (r_src << r_shift);
        end
        bot_data = (r_rdata & ~low_mask) | (r_src >> (4'd8 - {1'b0, r_shift}));
    end

    // Memory port selection.
    always_comb begin
        we    = i_cmd.clr_wr || i_cmd.wr_top || i_cmd.wr_bot;
        re    = i_cmd.rd_top || i_cmd.rd_bot;
        raddr = i_cmd.rd_bot ? bot_addr : top_addr;
        if (i_cmd.clr_wr) begin
            waddr = r_clr_cnt;
            wdata = 8'd0;
        end else if (i_cmd.wr_bot) begin
            waddr = bot_addr;
            wdata = bot_data;
        end else begin
            waddr = top_addr;
            wdata = top_data;
        end
    end

    // Store write port.
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
    end

    // Store read port, registered.
    always_ff @(posedge i_clk) begin
        if (re) begin
            r_rdata <= r_mem[raddr];
        end
    end

    assign o_read_data = r_rd;
    assign o_blit_done = r_done;
    assign o_req_error = r_err;

endmodule

@@ hdl/paged_mono_framebuffer_blitter_core.sv @@
// A put_pixel request does one read-modify-write of the target byte, read_byte one read
// (neither touches the store off screen), blit_data up to two read-modify-writes through
// the single store port, blit_start and unknown requests no store access, and clear a sweep
// of the whole store. Throughput: one request at a time; busy stays high until the result
// strobe has passed. Reset (synchronous, active low) clears the blit state and then sweeps
// the store to zero with busy high and no result strobe; the receiver cannot stall.
module paged_mono_framebuffer_blitter_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] i_req_type,
    input  logic [7:0] i_pos_x,
    input  logic [7:0] i_pos_y,
    input  logic       i_pixel_on,
    input  logic [7:0] i_sprite_width,
    input  logic [7:0] i_sprite_height,
    input  logic [7:0] i_sprite_byte,
    output logic       o_result_valid,
    output logic [7:0] o_read_data,
    output logic       o_blit_done,
    output logic       o_req_error
);
    import pmfb_pkg::*;

`include "assert_macros.svh"

    t_cmd  cmd;
    t_stat stat;

    // Request sequencing.
    pmfb_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_req_type     (i_req_type),
        .i_stat         (stat),
        .o_cmd          (cmd),
        .o_busy         (busy),
        .o_result_valid (o_result_valid)
    );

    // Frame store and blit arithmetic.
    pmfb_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_req_type      (i_req_type),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_pixel_on      (i_pixel_on),
        .i_sprite_width  (i_sprite_width),
        .i_sprite_height (i_sprite_height),
        .i_sprite_byte   (i_sprite_byte),
        .o_stat          (stat),
        .o_read_data     (o_read_data),
        .o_blit_done     (o_blit_done),
        .o_req_error     (o_req_error)
    );

    // An accepted request keeps the block busy in the next cycle.
    `ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // The result strobe lasts one cycle and falls back to idle.
    `ASSERT_NEXT(a_strobe_once, o_result_valid, !o_result_valid && !busy)
    // The target byte is only read or written at a location found on screen.
    `ASSERT_IMPL(a_write_on_screen, cmd.wr_top || cmd.rd_top, stat.top_ok)
    // A stray blit byte never completes a sprite.
    `ASSERT_IMPL(a_done_err_excl, o_result_valid, !(o_blit_done && o_req_error))

endmodule
